[src/atpt_pkg.sv]
// Shared types and constants for the ANSI text to planar tile converter.
// Used by the front parser, the command queue, the tile back end and the top level.
package atpt_pkg;

	typedef enum logic [1:0] {
		GLYPH_BLANK,
		GLYPH_HASH,
		GLYPH_RING
	} glyph_t;

	typedef struct packed {
		logic [2:0] fore;
		logic [1:0] back;
		glyph_t     glyph;
	} draw_cmd_t;

	typedef struct packed {
		logic emitting;
		logic pop;
	} back_status_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [7:0] BYTE_ESC      = 8'h1b;
	localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
	localparam logic [7:0] BYTE_SEMI     = 8'h3b;
	localparam logic [7:0] BYTE_M        = 8'h6d;
	localparam logic [7:0] BYTE_HASH     = 8'h23;
	localparam logic [7:0] BYTE_RING     = 8'h4f;
	localparam logic [7:0] BYTE_ZERO     = 8'h30;

	localparam logic [7:0][2:0] HASH_ROWS = {3'd2, 3'd2, 3'd7, 3'd2, 3'd2, 3'd7, 3'd2, 3'd2};
	localparam logic [7:0][2:0] RING_ROWS = {3'd2, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd2};

	function automatic logic glyph_bit(glyph_t g, logic [2:0] row, logic [1:0] col);
		logic [2:0] pat;
		case (g)
			GLYPH_HASH: pat = HASH_ROWS[row];
			GLYPH_RING: pat = RING_ROWS[row];
			default:    pat = 3'd0;
		endcase
		return (col == 2'd3) ? 1'b0 : pat[col];
	endfunction

endpackage

[src/atpt_front.sv]
// Front end: accepts text bytes, parses escape sequences and tracks the colour pair.
// Issues one draw command per drawn byte into the queue. Depends on atpt_pkg.
module atpt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           in_byte,
	output logic                 push,
	output atpt_pkg::draw_cmd_t  cmd
);

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_ESC,
		MODE_PARAM
	} mode_t;

	localparam logic [6:0] ATTR_A = 7'h47;
	localparam logic [6:0] ATTR_B = 7'h4f;
	localparam logic [6:0] ATTR_C = 7'h5f;
	localparam logic [6:0] ATTR_D = 7'h7f;
	localparam logic [6:0] ATTR_E = 7'h07;
	localparam logic [6:0] ATTR_F = 7'h78;

	localparam logic [7:0] BYTE_ZERO_L = atpt_pkg::BYTE_ZERO;

	mode_t      mode_q, mode_d;
	logic [7:0] acc_q, acc_d;
	logic [6:0] attr_q, attr_d;
	logic [2:0] fore_q, fore_d;
	logic [1:0] back_q, back_d;
	logic       draw;

	mode_t      pm_mode;
	logic [7:0] pm_acc;
	logic [6:0] pm_attr;
	logic [6:0] attr_applied;
	logic [7:0] acc_digit;
	logic [7:0] p_m30;
	logic [7:0] p_m40;

	atpt_pkg::glyph_t glyph_sel;

	assign p_m30     = acc_q - 8'd30;
	assign p_m40     = acc_q - 8'd40;
	assign acc_digit = (acc_q << 3) + (acc_q << 1) + (in_byte - BYTE_ZERO_L);

	always_comb begin
		attr_applied = attr_q;
		if (acc_q == 8'd0) begin
			attr_applied = attr_q & 7'h3f;
		end else if (acc_q == 8'd1) begin
			attr_applied = attr_q | 7'h40;
		end else if (acc_q >= 8'd30 && acc_q <= 8'd39) begin
			attr_applied = {attr_q[6], p_m30[2:0], attr_q[2:0]};
		end else if (acc_q >= 8'd40 && acc_q <= 8'd49) begin
			attr_applied = {attr_q[6:3], p_m40[2:0]};
		end
	end

	always_comb begin
		if (in_byte == atpt_pkg::BYTE_M || in_byte == atpt_pkg::BYTE_SEMI) begin
			pm_attr = attr_applied;
			pm_acc  = 8'd0;
			pm_mode = (in_byte == atpt_pkg::BYTE_M) ? MODE_TEXT : MODE_PARAM;
		end else begin
			pm_attr = attr_q;
			pm_acc  = acc_digit;
			pm_mode = MODE_PARAM;
		end
	end

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		attr_d = attr_q;
		fore_d = fore_q;
		back_d = back_q;
		draw   = 1'b0;
		unique case (mode_q)
			MODE_ESC: begin
				if (in_byte == atpt_pkg::BYTE_LBRACKET) begin
					mode_d = MODE_PARAM;
				end else begin
					mode_d = pm_mode;
					acc_d  = pm_acc;
					attr_d = pm_attr;
				end
			end
			MODE_PARAM: begin
				mode_d = pm_mode;
				acc_d  = pm_acc;
				attr_d = pm_attr;
			end
			default: begin
				if (in_byte == atpt_pkg::BYTE_ESC) begin
					mode_d = MODE_ESC;
					acc_d  = 8'd0;
				end else begin
					mode_d = MODE_TEXT;
					draw   = 1'b1;
					case (attr_q)
						ATTR_A: begin fore_d = 3'd1; back_d = 2'd3; end
						ATTR_B: begin fore_d = 3'd2; back_d = 2'd3; end
						ATTR_C: begin fore_d = 3'd4; back_d = 2'd3; end
						ATTR_D: begin fore_d = 3'd5; back_d = 2'd3; end
						ATTR_E: begin fore_d = 3'd0; back_d = 2'd3; end
						ATTR_F: begin fore_d = 3'd5; back_d = 2'd0; end
						default: ;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
			acc_q  <= 8'd0;
			attr_q <= 7'd0;
			fore_q <= 3'd0;
			back_q <= 2'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			attr_q <= attr_d;
			fore_q <= fore_d;
			back_q <= back_d;
		end
	end

	always_comb begin
		if (in_byte == atpt_pkg::BYTE_HASH) begin
			glyph_sel = atpt_pkg::GLYPH_HASH;
		end else if (in_byte == atpt_pkg::BYTE_RING) begin
			glyph_sel = atpt_pkg::GLYPH_RING;
		end else begin
			glyph_sel = atpt_pkg::GLYPH_BLANK;
		end
	end

	assign push      = accept && draw;
	assign cmd.fore  = fore_d;
	assign cmd.back  = back_d;
	assign cmd.glyph = glyph_sel;

endmodule

[src/atpt_fifo.sv]
// Short command queue between the parser and the tile back end.
// Holds draw commands in registers. Depends on atpt_pkg.
module atpt_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  atpt_pkg::draw_cmd_t         push_data,
	input  logic                        pop,
	output atpt_pkg::draw_cmd_t         pop_data,
	output logic                        full,
	output logic                        empty,
	output logic [atpt_pkg::QCNT_W-1:0] count
);

	atpt_pkg::draw_cmd_t               mem_q [atpt_pkg::QDEPTH];
	logic [atpt_pkg::QPTR_W-1:0]       wr_q;
	logic [atpt_pkg::QPTR_W-1:0]       rd_q;
	logic [atpt_pkg::QCNT_W-1:0]       cnt_q;

	assign full     = (cnt_q == atpt_pkg::QCNT_W'(atpt_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign count    = cnt_q;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/atpt_back.sv]
// Back end: shifts glyph columns into the eight-row, four-plane tile and emits
// each finished tile as 16 words through an output register. Depends on atpt_pkg.
module atpt_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  atpt_pkg::draw_cmd_t     q_data,
	output atpt_pkg::back_status_t  status,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [15:0]             tile_word,
	output logic                    last_word
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	state_t              state_q;
	atpt_pkg::draw_cmd_t cmd_q;
	logic [1:0]          col_q;
	logic [2:0]          ccount_q;
	logic [3:0]          idx_q;
	logic [3:0][7:0]     rows_q [8];
	logic                out_valid_q;
	logic [15:0]         word_q;
	logic                last_q;

	logic                pop;
	logic                load_out;
	logic [2:0]          ccount_nx;
	logic [15:0]         word_nx;

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign load_out  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign ccount_nx = ccount_q + 3'd1;
	assign word_nx   = idx_q[3] ? {rows_q[idx_q[2:0]][3], rows_q[idx_q[2:0]][2]}
	                            : {rows_q[idx_q[2:0]][1], rows_q[idx_q[2:0]][0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			col_q       <= 2'd0;
			ccount_q    <= 3'd0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
			word_q      <= 16'd0;
			last_q      <= 1'b0;
			for (int r = 0; r < 8; r++) begin
				rows_q[r] <= '0;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cmd_q   <= q_data;
						col_q   <= 2'd0;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					for (int r = 0; r < 8; r++) begin
						logic [2:0] colour;
						colour = atpt_pkg::glyph_bit(cmd_q.glyph, 3'(r), col_q) ? cmd_q.fore
						                                                        : {1'b0, cmd_q.back};
						for (int p = 0; p < 3; p++) begin
							rows_q[r][p] <= {rows_q[r][p][6:0], colour[p]};
						end
						rows_q[r][3] <= {rows_q[r][3][6:0], 1'b0};
					end
					ccount_q <= ccount_nx;
					col_q    <= col_q + 2'd1;
					if (ccount_nx == 3'd0) begin
						idx_q   <= 4'd0;
						state_q <= ST_EMIT;
					end else if (col_q == 2'd2) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						word_q <= word_nx;
						last_q <= (idx_q == 4'd15);
						idx_q  <= idx_q + 4'd1;
						if (idx_q == 4'd15) begin
							state_q <= (col_q == 2'd3) ? ST_IDLE : ST_SHIFT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign status.emitting = (state_q == ST_EMIT);
	assign status.pop      = pop;
	assign out_valid       = out_valid_q;
	assign tile_word       = word_q;
	assign last_word       = last_q;

endmodule

[src/ansi_text_to_planar_tiles.sv]
// ANSI text to planar tiles: escape bytes are taken while the queue has room.
// A drawn byte is fetched from the queue and then shifted in as three glyph columns;
// a completed tile is emitted as 16 words, one word per cycle unless the output stalls.
// The first word is registered in the emit state that follows the tile's last column.
// The four-entry command queue decouples parser and back end.
// Asynchronous reset clears parse state, attribute, colours, column count and all planes.
module ansi_text_to_planar_tiles (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] tile_word,
	output logic        last_word
);

	logic                        accept;
	logic                        push;
	atpt_pkg::draw_cmd_t         push_cmd;
	atpt_pkg::draw_cmd_t         pop_cmd;
	logic                        q_full;
	logic                        q_empty;
	logic [atpt_pkg::QCNT_W-1:0] q_count;
	atpt_pkg::back_status_t      back_status;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	atpt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.push    (push),
		.cmd     (push_cmd)
	);

	atpt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (back_status.pop),
		.pop_data  (pop_cmd),
		.full      (q_full),
		.empty     (q_empty),
		.count     (q_count)
	);

	atpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_cmd),
		.status    (back_status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tile_word (tile_word),
		.last_word (last_word)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("command pushed into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= atpt_pkg::QCNT_W'(atpt_pkg::QDEPTH))
		else $error("queue count out of range");

	a_no_pop_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(back_status.pop && back_status.emitting))
		else $error("command fetched while a tile is being emitted");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.pop |-> !q_empty)
		else $error("command fetched from an empty queue");

endmodule
